FILE: sv/mexp_pkg.sv
// Package for the modular exponentiation block: operand width, word type.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int OPERAND_WIDTH = 64;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_count;

endpackage

FILE: sv/mexp_in_if.sv
// Input channel: base, exponent and modulus with valid/ready.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

interface mexp_in_if;
    import mexp_pkg::*;

    logic  valid;
    logic  ready;
    t_word base_value;
    t_word exponent_value;
    t_word modulus_value;

    modport source (output valid, output base_value, output exponent_value,
                    output modulus_value, input ready);
    modport sink   (input valid, input base_value, input exponent_value,
                    input modulus_value, output ready);
endinterface

FILE: sv/mexp_out_if.sv
// Output channel: power result and zero modulus flag with valid/ready.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

interface mexp_out_if;
    import mexp_pkg::*;

    logic  valid;
    logic  ready;
    t_word power_result;
    logic  zero_modulus_error;

    modport source (output valid, output power_result, output zero_modulus_error,
                    input ready);
    modport sink   (input valid, input power_result, input zero_modulus_error,
                    output ready);
endinterface

FILE: sv/mexp_step_unit.sv
// Shared step unit: (2*acc + addend) mod m for acc < m, addend < m.
// Serves both the remainder steps and the shift-and-add products. Uses mexp_pkg.
`timescale 1ns / 1ps

module mexp_step_unit (
    input  mexp_pkg::t_word i_acc,
    input  mexp_pkg::t_word i_addend,
    input  mexp_pkg::t_word i_modulus,
    output mexp_pkg::t_word o_result
);
    import mexp_pkg::*;

    localparam int TW = OPERAND_WIDTH + 2;

    logic [TW-1:0] w_sum;
    logic [TW-1:0] w_m1;
    logic [TW-1:0] w_m2;
    logic [TW-1:0] w_d1;
    logic [TW-1:0] w_d2;

    // sum is below 3m, so one of three candidates is the residue
    assign w_sum = {1'b0, i_acc, 1'b0} + {2'b00, i_addend};
    assign w_m1  = {2'b00, i_modulus};
    assign w_m2  = {1'b0, i_modulus, 1'b0};
    assign w_d1  = w_sum - w_m1;
    assign w_d2  = w_sum - w_m2;

    always_comb begin
        if (w_sum >= w_m2) begin
            o_result = w_d2[OPERAND_WIDTH-1:0];
        end else if (w_sum >= w_m1) begin
            o_result = w_d1[OPERAND_WIDTH-1:0];
        end else begin
            o_result = w_sum[OPERAND_WIDTH-1:0];
        end
    end

endmodule

FILE: sv/modular_exponentiation_64.sv
// Top level: sequencer for right-to-left square-and-multiply over one step unit.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if, mexp_step_unit.
//
// Usage:
//   i_in carries base, exponent and modulus; an item is taken when valid and
//   ready are both high. ready is high only while the sequencer is idle.
//   o_out carries the result and the zero modulus flag from an output
//   register; it holds until the receiver takes it.
// Timing: every modular product and the initial base reduction run through
//   the shared step unit one operand bit per cycle. A zero modulus skips the
//   reduction and goes straight to the result; a zero exponent ends after
//   the reduction. One item is in flight at a time; ready returns as the
//   result is loaded into the output register.
// Stall: while a result waits, the next item may be taken and computed; its
//   result waits in the sequencer until the output register is free.
// Reset: synchronous, active low; sequencer returns to idle, output empties.
`timescale 1ns / 1ps

module modular_exponentiation_64 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mexp_in_if.sink       i_in,
    mexp_out_if.source    o_out
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_NEXT,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

    t_state r_state;
    t_word  r_acc;
    t_word  r_base;
    t_word  r_exp;
    t_word  r_mod;
    t_word  r_work;
    t_word  r_x;
    t_count r_cnt;
    logic   r_err;
    logic   r_out_valid;
    t_word  r_out_result;
    logic   r_out_err;

    t_word  w_addend;
    t_word  w_step;
    logic   w_last;

    always_comb begin
        if (r_state == S_RED) begin
            w_addend = {{(OPERAND_WIDTH-1){1'b0}}, r_x[OPERAND_WIDTH-1]};
        end else if (r_x[OPERAND_WIDTH-1]) begin
            w_addend = r_base;
        end else begin
            w_addend = '0;
        end
    end

    assign w_last = (r_cnt == t_count'(OPERAND_WIDTH - 1));

    mexp_step_unit u_step (
        .i_acc     (r_work),
        .i_addend  (w_addend),
        .i_modulus (r_mod),
        .o_result  (w_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // load the output register as soon as it is free
            if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid  <= 1'b1;
                r_out_result <= r_acc;
                r_out_err    <= r_err;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_mod  <= i_in.modulus_value;
                        r_exp  <= i_in.exponent_value;
                        r_x    <= i_in.base_value;
                        r_work <= '0;
                        r_cnt  <= '0;
                        if (i_in.modulus_value == '0) begin
                            r_acc   <= '0;
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_acc   <= t_word'(1);
                            r_err   <= 1'b0;
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    // remainder of base by modulus, one dividend bit a cycle
                    r_work <= w_step;
                    r_x    <= {r_x[OPERAND_WIDTH-2:0], 1'b0};
                    r_cnt  <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_base  <= w_step;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_work <= '0;
                    r_cnt  <= '0;
                    if (r_exp == '0) begin
                        r_state <= S_DONE;
                    end else if (r_exp[0]) begin
                        r_x     <= r_acc;
                        r_state <= S_MUL;
                    end else begin
                        r_x     <= r_base;
                        r_state <= S_SQR;
                    end
                end
                S_MUL: begin
                    r_work <= w_step;
                    r_x    <= {r_x[OPERAND_WIDTH-2:0], 1'b0};
                    r_cnt  <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_acc   <= w_step;
                        r_work  <= '0;
                        r_x     <= r_base;
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_work <= w_step;
                    r_x    <= {r_x[OPERAND_WIDTH-2:0], 1'b0};
                    r_cnt  <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_base  <= w_step;
                        r_exp   <= {1'b0, r_exp[OPERAND_WIDTH-1:1]};
                        r_state <= S_NEXT;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready               = (r_state == S_IDLE);
    assign o_out.valid              = r_out_valid;
    assign o_out.power_result       = r_out_result;
    assign o_out.zero_modulus_error = r_out_err;

endmodule

FILE: sv/mexp_checker.sv
// Port-level checks for modular_exponentiation_64, attached by bind.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input mexp_pkg::t_word i_power_result,
    input logic            i_zero_modulus_error
);
    import mexp_pkg::*;

    // a result that is offered stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_power_result) && $stable(i_zero_modulus_error))
        else $error("output item changed while stalled");

    // a zero modulus forces a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zero_modulus_error |-> i_power_result == '0)
        else $error("zero modulus flagged with nonzero result");

    // one item at a time: busy right after an item is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an item was taken");

endmodule

bind modular_exponentiation_64 mexp_checker u_mexp_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in.valid),
    .i_in_ready           (i_in.ready),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_power_result       (o_out.power_result),
    .i_zero_modulus_error (o_out.zero_modulus_error)
);
